/* rtl/core/wrc_pkg.sv */
`default_nettype none

package wrc_pkg;

	localparam int MAX_WIDTH  = 128;
	localparam int MAX_HEIGHT = 128;
	localparam int MAX_KERNEL = 5;

	localparam int POS_W     = 7;
	localparam int CH_W      = 8;
	localparam int PIX_W     = 3 * CH_W;
	localparam int KS_W      = 3;
	localparam int HALF_W    = KS_W - 1;
	localparam int DIM_W     = 8;
	localparam int SCALE_W   = 16;
	localparam int BIAS_W    = 17;
	localparam int COEF_W    = 16;
	localparam int FRAC_W    = 20;
	localparam int BIAS_SH   = 12;
	localparam int APB_AW    = 5;
	localparam int APB_DW    = 32;
	localparam int MOD_CNT_W = 3;

	localparam logic [1:0] REQ_PIXEL = 2'd0;
	localparam logic [1:0] REQ_COEF  = 2'd1;
	localparam logic [1:0] REQ_QUERY = 2'd2;

	localparam logic [2:0] REG_KSIZE  = 3'd0;
	localparam logic [2:0] REG_WIDTH  = 3'd1;
	localparam logic [2:0] REG_HEIGHT = 3'd2;
	localparam logic [2:0] REG_SCALE  = 3'd3;
	localparam logic [2:0] REG_BIAS   = 3'd4;

	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;

	localparam logic [KS_W-1:0]           KS_RST    = 3'd5;
	localparam logic [DIM_W-1:0]          DIM_RST   = 8'd128;
	localparam logic [SCALE_W-1:0]        SCALE_RST = 16'd4096;
	localparam logic signed [BIAS_W-1:0]  BIAS_RST  = 17'sd0;
	localparam logic [CH_W-1:0]           CH_MAX    = 8'd255;

	typedef struct packed {
		logic [1:0]               req_type;
		logic [POS_W-1:0]         pos_x;
		logic [POS_W-1:0]         pos_y;
		logic [CH_W-1:0]          red_in;
		logic [CH_W-1:0]          green_in;
		logic [CH_W-1:0]          blue_in;
		logic [2:0]               coef_col;
		logic [2:0]               coef_row;
		logic signed [COEF_W-1:0] coef_value;
	} req_t;

	typedef struct packed {
		logic [CH_W-1:0] red_out;
		logic [CH_W-1:0] green_out;
		logic [CH_W-1:0] blue_out;
	} rsp_t;

	typedef struct packed {
		logic [KS_W-1:0]          kernel_size;
		logic [DIM_W-1:0]         image_width;
		logic [DIM_W-1:0]         image_height;
		logic [SCALE_W-1:0]       scale_factor;
		logic signed [BIAS_W-1:0] bias_value;
	} cfg_t;

	typedef struct packed {
		logic       start;
		logic       wr_pix;
		logic       wr_coef;
		logic       mod_step;
		logic       back_step;
		logic       issue;
		logic       mul;
		logic [1:0] ch;
		logic       load_out;
	} cmd_t;

	typedef struct packed {
		logic [HALF_W-1:0] half;
		logic              ks_zero;
		logic              col_last;
		logic              row_last;
		logic              pipe_busy;
	} sts_t;

endpackage

`default_nettype wire

/* rtl/core/wraparound_rgb_convolution.sv */
`default_nettype none

// Wraparound RGB convolution. Pixel writes and coefficient writes are taken in the
// idle state. A filter query at (pos_x, pos_y) walks the kernel over the stored
// image, one pixel read per cycle from a single-port pixel memory, with
// coordinates wrapping modulo the programmed image size; it occupies the block
// while it reduces the query position modulo the image size bit by bit, steps
// back by ks/2 (ks: kernel side in use), reads the ks*ks pixels, drains the
// multiply pipeline and scales, biases and clamps the three channels through
// one shared multiplier (an empty kernel reads no pixels). New requests are
// taken while a finished result still waits on the response channel.
// Configuration writes are expected only while the block is idle; unwritten
// pixels read as garbage.
module wraparound_rgb_convolution #(
	parameter int MAX_WIDTH  = wrc_pkg::MAX_WIDTH,
	parameter int MAX_HEIGHT = wrc_pkg::MAX_HEIGHT,
	parameter int MAX_KERNEL = wrc_pkg::MAX_KERNEL
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       req_valid,
	output logic                            req_stall,
	input  wire wrc_pkg::req_t              req,
	output logic                            rsp_valid,
	input  wire logic                       rsp_stall,
	output wrc_pkg::rsp_t                   rsp,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [wrc_pkg::APB_AW-1:0] paddr,
	input  wire logic [wrc_pkg::APB_DW-1:0] pwdata,
	output logic      [wrc_pkg::APB_DW-1:0] prdata,
	output logic                            pready
);

	wrc_pkg::cfg_t cfg;
	wrc_pkg::cmd_t cmd;
	wrc_pkg::sts_t sts;

	assign pready = 1'b1;

	wrc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	wrc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_type  (req.req_type),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	wrc_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_KERNEL (MAX_KERNEL)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire

/* rtl/core/wrc_cfg.sv */
`default_nettype none

module wrc_cfg (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [wrc_pkg::APB_AW-1:0]  paddr,
	input  wire logic [wrc_pkg::APB_DW-1:0]  pwdata,
	output logic      [wrc_pkg::APB_DW-1:0]  prdata,
	output wrc_pkg::cfg_t                    cfg
);

	wrc_pkg::cfg_t cfg_q;
	logic          wr;
	logic [2:0]    idx;

	assign wr  = psel & penable & pwrite;
	assign idx = paddr[wrc_pkg::APB_AW-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kernel_size  <= wrc_pkg::KS_RST;
			cfg_q.image_width  <= wrc_pkg::DIM_RST;
			cfg_q.image_height <= wrc_pkg::DIM_RST;
			cfg_q.scale_factor <= wrc_pkg::SCALE_RST;
			cfg_q.bias_value   <= wrc_pkg::BIAS_RST;
		end else if (wr) begin
			case (idx)
				wrc_pkg::REG_KSIZE:  cfg_q.kernel_size  <= pwdata[wrc_pkg::KS_W-1:0];
				wrc_pkg::REG_WIDTH:  cfg_q.image_width  <= pwdata[wrc_pkg::DIM_W-1:0];
				wrc_pkg::REG_HEIGHT: cfg_q.image_height <= pwdata[wrc_pkg::DIM_W-1:0];
				wrc_pkg::REG_SCALE:  cfg_q.scale_factor <= pwdata[wrc_pkg::SCALE_W-1:0];
				wrc_pkg::REG_BIAS:   cfg_q.bias_value   <= signed'(pwdata[wrc_pkg::BIAS_W-1:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			wrc_pkg::REG_KSIZE:  prdata = wrc_pkg::APB_DW'(cfg_q.kernel_size);
			wrc_pkg::REG_WIDTH:  prdata = wrc_pkg::APB_DW'(cfg_q.image_width);
			wrc_pkg::REG_HEIGHT: prdata = wrc_pkg::APB_DW'(cfg_q.image_height);
			wrc_pkg::REG_SCALE:  prdata = wrc_pkg::APB_DW'(cfg_q.scale_factor);
			wrc_pkg::REG_BIAS:   prdata = {{(wrc_pkg::APB_DW-wrc_pkg::BIAS_W){1'b0}},
				cfg_q.bias_value};
			default:             prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

/* rtl/core/wrc_ctrl.sv */
`default_nettype none

module wrc_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	input  wire logic [1:0]    req_type,
	output logic               req_stall,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	input  wire wrc_pkg::sts_t sts,
	output wrc_pkg::cmd_t      cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MOD   = 3'd1;
	localparam logic [2:0] S_BACK  = 3'd2;
	localparam logic [2:0] S_SWEEP = 3'd3;
	localparam logic [2:0] S_DRAIN = 3'd4;
	localparam logic [2:0] S_MUL   = 3'd5;
	localparam logic [2:0] S_CLAMP = 3'd6;
	localparam logic [2:0] S_OUT   = 3'd7;

	localparam int CW = wrc_pkg::MOD_CNT_W;

	logic [2:0]    state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic          rsp_valid_q, rsp_valid_d;
	logic          accept;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid & ~req_stall;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req_type)
						wrc_pkg::REQ_PIXEL: cmd.wr_pix = 1'b1;
						wrc_pkg::REQ_COEF:  cmd.wr_coef = 1'b1;
						wrc_pkg::REQ_QUERY: begin
							cmd.start = 1'b1;
							cnt_d     = '0;
							state_d   = S_MOD;
						end
						default: ;
					endcase
				end
			end
			S_MOD: begin
				cmd.mod_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == CW'(wrc_pkg::POS_W - 1)) begin
					cnt_d = '0;
					if (sts.half != '0)
						state_d = S_BACK;
					else if (sts.ks_zero)
						state_d = S_MUL;
					else
						state_d = S_SWEEP;
				end
			end
			S_BACK: begin
				cmd.back_step = 1'b1;
				cnt_d         = cnt_q + 1'b1;
				if (cnt_q == CW'(sts.half) - CW'(1)) begin
					cnt_d   = '0;
					state_d = S_SWEEP;
				end
			end
			S_SWEEP: begin
				cmd.issue = 1'b1;
				if (sts.col_last && sts.row_last)
					state_d = S_DRAIN;
			end
			S_DRAIN: begin
				if (!sts.pipe_busy) begin
					cnt_d   = '0;
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				cmd.ch  = cnt_q[1:0];
				cnt_d   = cnt_q + 1'b1;
				if (cnt_q[1:0] == wrc_pkg::CH_BLUE)
					state_d = S_CLAMP;
			end
			S_CLAMP: state_d = S_OUT;
			S_OUT: begin
				if (!rsp_valid_q || !rsp_stall) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		rsp_valid_d = rsp_valid_q;
		if (cmd.load_out)
			rsp_valid_d = 1'b1;
		else if (!rsp_stall)
			rsp_valid_d = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/wrc_dp.sv */
`default_nettype none

module wrc_dp #(
	parameter int MAX_WIDTH  = wrc_pkg::MAX_WIDTH,
	parameter int MAX_HEIGHT = wrc_pkg::MAX_HEIGHT,
	parameter int MAX_KERNEL = wrc_pkg::MAX_KERNEL
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire wrc_pkg::cfg_t cfg,
	input  wire wrc_pkg::req_t req,
	input  wire wrc_pkg::cmd_t cmd,
	output wrc_pkg::sts_t      sts,
	output wrc_pkg::rsp_t      rsp
);

	localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int DEPTH = 1 << (XW + YW);
	localparam int KK    = MAX_KERNEL * MAX_KERNEL;
	localparam int CIW   = (KK > 1) ? $clog2(KK) : 1;
	localparam int PRW   = wrc_pkg::CH_W + 1 + wrc_pkg::COEF_W;
	localparam int SUMW  = PRW + $clog2(KK);
	localparam int PW    = SUMW + wrc_pkg::SCALE_W + 1;
	localparam int KW    = wrc_pkg::KS_W;
	localparam int PX    = wrc_pkg::POS_W;
	localparam int CHW   = wrc_pkg::CH_W;
	localparam logic signed [PW-1:0] SAT_LIM =
		PW'(longint'(wrc_pkg::CH_MAX) << wrc_pkg::FRAC_W);

	logic [WW-1:0] w;
	logic [HW-1:0] h;
	logic [KW-1:0] ks;

	logic [PX-1:0] px_q, py_q;
	logic [XW-1:0] x0_q, xx_q;
	logic [YW-1:0] yy_q;
	logic [KW-1:0] kx_q, ky_q;

	logic [XW:0]   xr, xs;
	logic [YW:0]   yr, ys;
	logic [XW-1:0] xb, xi;
	logic [YW-1:0] yb, yi;

	logic [wrc_pkg::PIX_W-1:0]          pix_mem [DEPTH];
	logic signed [wrc_pkg::COEF_W-1:0]  coef_q [KK];
	logic [XW+YW-1:0]                   wr_addr, rd_addr;
	logic                               pix_ok, coef_ok;
	logic [CIW-1:0]                     cw_idx, cr_idx;

	logic [wrc_pkg::PIX_W-1:0]          pix_s1;
	logic signed [wrc_pkg::COEF_W-1:0]  coef_s1;
	logic                               v_s1, v_s2;
	logic signed [PRW-1:0]              prod_s2 [3];
	logic signed [SUMW-1:0]             acc_q [3];

	logic signed [SUMW-1:0]             sum_sel;
	logic signed [wrc_pkg::SCALE_W:0]   scale_s;
	logic signed [PW-1:0]               mprod_s1;
	logic [1:0]                         mch_s1;
	logic                               mv_s1;
	logic signed [PW-1:0]               vsum;
	logic [CHW-1:0]                     clamped;
	logic [CHW-1:0]                     res_q [3];
	wrc_pkg::rsp_t                      rsp_q;

	always_comb begin
		if (cfg.image_width == '0)
			w = WW'(1);
		else if (32'(cfg.image_width) > 32'(MAX_WIDTH))
			w = WW'(MAX_WIDTH);
		else
			w = WW'(cfg.image_width);
		if (cfg.image_height == '0)
			h = HW'(1);
		else if (32'(cfg.image_height) > 32'(MAX_HEIGHT))
			h = HW'(MAX_HEIGHT);
		else
			h = HW'(cfg.image_height);
		if (32'(cfg.kernel_size) > 32'(MAX_KERNEL))
			ks = KW'(MAX_KERNEL);
		else
			ks = cfg.kernel_size;
	end

	assign sts.half      = ks[KW-1:1];
	assign sts.ks_zero   = (ks == '0);
	assign sts.col_last  = (kx_q == ks - 1'b1);
	assign sts.row_last  = (ky_q == ks - 1'b1);
	assign sts.pipe_busy = v_s1 | v_s2;

	assign xr = {x0_q, px_q[PX-1]};
	assign xs = (xr >= (XW+1)'(w)) ? xr - (XW+1)'(w) : xr;
	assign yr = {yy_q, py_q[PX-1]};
	assign ys = (yr >= (YW+1)'(h)) ? yr - (YW+1)'(h) : yr;
	assign xb = (x0_q == '0) ? XW'(w - WW'(1)) : x0_q - 1'b1;
	assign yb = (yy_q == '0) ? YW'(h - HW'(1)) : yy_q - 1'b1;
	assign xi = ((XW+1)'(xx_q) + 1'b1 == (XW+1)'(w)) ? '0 : xx_q + 1'b1;
	assign yi = ((YW+1)'(yy_q) + 1'b1 == (YW+1)'(h)) ? '0 : yy_q + 1'b1;

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			px_q <= req.pos_x;
			py_q <= req.pos_y;
			x0_q <= '0;
			xx_q <= '0;
			yy_q <= '0;
			kx_q <= '0;
			ky_q <= '0;
		end else if (cmd.mod_step) begin
			px_q <= {px_q[PX-2:0], 1'b0};
			py_q <= {py_q[PX-2:0], 1'b0};
			x0_q <= XW'(xs);
			xx_q <= XW'(xs);
			yy_q <= YW'(ys);
		end else if (cmd.back_step) begin
			x0_q <= xb;
			xx_q <= xb;
			yy_q <= yb;
		end else if (cmd.issue) begin
			if (sts.col_last) begin
				xx_q <= x0_q;
				yy_q <= yi;
				kx_q <= '0;
				ky_q <= ky_q + 1'b1;
			end else begin
				xx_q <= xi;
				kx_q <= kx_q + 1'b1;
			end
		end
	end

	assign pix_ok  = (32'(req.pos_x) < 32'(MAX_WIDTH)) && (32'(req.pos_y) < 32'(MAX_HEIGHT));
	assign wr_addr = {YW'(req.pos_y), XW'(req.pos_x)};
	assign rd_addr = {yy_q, xx_q};

	always_ff @(posedge clk) begin
		if (cmd.wr_pix && pix_ok)
			pix_mem[wr_addr] <= {req.red_in, req.green_in, req.blue_in};
		if (cmd.issue)
			pix_s1 <= pix_mem[rd_addr];
	end

	assign coef_ok = (32'(req.coef_col) < 32'(MAX_KERNEL)) &&
		(32'(req.coef_row) < 32'(MAX_KERNEL));
	assign cw_idx  = CIW'(int'(req.coef_row) * MAX_KERNEL + int'(req.coef_col));
	assign cr_idx  = CIW'(int'(ky_q) * MAX_KERNEL + int'(kx_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KK; i++)
				coef_q[i] <= '0;
		end else if (cmd.wr_coef && coef_ok) begin
			coef_q[cw_idx] <= req.coef_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			mv_s1 <= 1'b0;
		end else begin
			v_s1  <= cmd.issue;
			v_s2  <= v_s1;
			mv_s1 <= cmd.mul;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue)
			coef_s1 <= coef_q[cr_idx];
		for (int i = 0; i < 3; i++) begin
			prod_s2[i] <= $signed({1'b0, pix_s1[wrc_pkg::PIX_W-1-CHW*i -: CHW]}) * coef_s1;
			if (cmd.start)
				acc_q[i] <= '0;
			else if (v_s2)
				acc_q[i] <= acc_q[i] + SUMW'(prod_s2[i]);
		end
	end

	assign scale_s = signed'({1'b0, cfg.scale_factor});

	always_comb begin
		case (cmd.ch)
			wrc_pkg::CH_RED:   sum_sel = acc_q[0];
			wrc_pkg::CH_GREEN: sum_sel = acc_q[1];
			default:           sum_sel = acc_q[2];
		endcase
	end

	always_ff @(posedge clk) begin
		mprod_s1 <= PW'(sum_sel) * PW'(scale_s);
		mch_s1   <= cmd.ch;
	end

	assign vsum = mprod_s1 + (PW'(cfg.bias_value) <<< wrc_pkg::BIAS_SH);

	always_comb begin
		if (vsum < 0)
			clamped = '0;
		else if (vsum >= SAT_LIM)
			clamped = wrc_pkg::CH_MAX;
		else
			clamped = vsum[wrc_pkg::FRAC_W+CHW-1:wrc_pkg::FRAC_W];
	end

	always_ff @(posedge clk) begin
		if (mv_s1) begin
			case (mch_s1)
				wrc_pkg::CH_RED:   res_q[0] <= clamped;
				wrc_pkg::CH_GREEN: res_q[1] <= clamped;
				default:           res_q[2] <= clamped;
			endcase
		end
		if (cmd.load_out) begin
			rsp_q.red_out   <= res_q[0];
			rsp_q.green_out <= res_q[1];
			rsp_q.blue_out  <= res_q[2];
		end
	end

	assign rsp = rsp_q;

endmodule

`default_nettype wire

/* rtl/core/wrc_checker.sv */
`default_nettype none

module wrc_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          req_valid,
	input wire logic          req_stall,
	input wire wrc_pkg::req_t req,
	input wire logic          rsp_valid,
	input wire logic          rsp_stall,
	input wire wrc_pkg::rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid)
		else $error("response dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> $stable(rsp))
		else $error("response changed while stalled");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req.req_type == wrc_pkg::REQ_QUERY |=> req_stall)
		else $error("request taken during a query");

	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req.req_type != wrc_pkg::REQ_QUERY && !rsp_valid
		|=> !rsp_valid)
		else $error("response after a write transfer");

endmodule

bind wraparound_rgb_convolution wrc_checker u_wrc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

`default_nettype wire
